// ===== src/uat_pkg.sv =====
// shared types and constants for the unsorted array table
// no dependencies
`timescale 1ns / 1ps

package uat_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int FUNC_W       = 2;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 5;
    localparam int FILL_W       = 6;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_SEARCH = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic    load;
        logic    scan;
        logic    shift;
        logic    ins;
        logic    dec;
        logic    res_load;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              match;
        logic              scan_end;
        logic              out_free;
    } sts_t;

endpackage

// ===== src/uat_ctrl.sv =====
// controller state machine for the unsorted array table
// depends on uat_pkg
`timescale 1ns / 1ps

module uat_ctrl
    import uat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_MISSING;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.func)
                    FUNC_INSERT:
                    begin
                        code_next  = sts.full ? ST_FULL : ST_OK;
                        state_next = S_RESP;
                    end
                    FUNC_DELETE, FUNC_SEARCH:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        code_next  = ST_MISSING;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.match)
                begin
                    code_next  = ST_OK;
                    state_next = (sts.func == FUNC_DELETE) ? S_SHIFT : S_RESP;
                end
                else if (sts.scan_end)
                begin
                    code_next  = ST_MISSING;
                    state_next = S_RESP;
                end
            end
            S_SHIFT:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = code_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.ins = (sts.func == FUNC_INSERT) && !sts.full;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                cmd.dec   = sts.scan_end;
            end
            S_RESP:
            begin
                cmd.res_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/uat_dp.sv =====
// datapath for the unsorted array table: entry memory, count, scan pointer, result register
// depends on uat_pkg
`timescale 1ns / 1ps

module uat_dp
    import uat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [IN_DATA_W-1:0]    in_data,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_DATA_W-1:0]   out_data
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0]  mem [CAPACITY];

    logic [FUNC_W-1:0] func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [KEY_W-1:0]  rd_data_reg;
    logic [AW-1:0]     pos_reg;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [FILL_W-1:0] out_fill_reg;

    logic              issue;
    logic              full;
    logic              match;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic [AW+POS_W-1:0]    pos_ext;
    logic [CNT_W+FILL_W-1:0] fill_ext;

    assign full  = (count_reg >= CNT_W'(CAPACITY));
    assign issue = (cmd.scan || cmd.shift) && (ptr_reg < count_reg);
    assign match = rd_valid_reg && (rd_data_reg == key_reg);

    assign sts.func     = func_reg;
    assign sts.full     = full;
    assign sts.match    = match;
    assign sts.scan_end = (ptr_reg >= count_reg) && !rd_valid_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        ptr_next      = ptr_reg;
        rd_valid_next = issue;
        if (cmd.load)
        begin
            ptr_next      = '0;
            rd_valid_next = 1'b0;
        end
        else if (issue)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = key_reg;
        if (cmd.ins)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift && rd_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_ptr_reg - 1'b1;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
            rd_ptr_reg  <= ptr_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // captured fields and position of the last hit or insert
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_data[FUNC_W-1:0];
            key_reg  <= in_data[FUNC_W+KEY_W-1:FUNC_W];
        end
        if (cmd.ins)
        begin
            pos_reg <= count_reg[AW-1:0];
        end
        else if (cmd.scan && match)
        begin
            pos_reg <= rd_ptr_reg;
        end
    end

    assign pos_ext  = {{POS_W{1'b0}}, pos_reg};
    assign fill_ext = {{FILL_W{1'b0}}, count_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_status_reg <= cmd.res_status;
            out_pos_reg    <= (cmd.res_status == ST_OK) ? pos_ext[POS_W-1:0] : '0;
            out_fill_reg   <= fill_ext[FILL_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_DATA_W - STATUS_W - POS_W - FILL_W){1'b0}},
                        out_fill_reg, out_pos_reg, out_status_reg};

endmodule

// ===== src/unsorted_array_table.sv =====
// top level of the unsorted array table: controller plus datapath
// depends on uat_pkg, uat_ctrl, uat_dp
`timescale 1ns / 1ps

// Bounded unsorted table of signed 32-bit keys with insert, delete and search, one
// transaction in and one result out per operation. Entries sit in a single-port-read
// memory that is scanned one entry per clock, so the memory read port sets the cost:
// insert or an unused code goes straight from execution to the result, search scans
// up to the hit (to the end of the table on a miss), and delete scans to the end of
// the table since the scan runs into the shift-down of the later entries. The block
// goes back to idle before the next transaction is taken, and a result that is still
// waiting on the output register holds back the loading of the next result, so a new
// transaction is taken while the previous result still waits on the output register.

module unsorted_array_table
    import uat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // func[1:0], key[33:2], zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // status[1:0], position[6:2], fill_count[12:7]
);

    cmd_t cmd;
    sts_t sts;

    uat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    uat_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("transaction accepted while previous one in flight");

    a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.ins, cmd.dec, cmd.res_load}))
        else $error("conflicting datapath commands");

    a_fail_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[STATUS_W-1:0] != ST_OK))
            |-> (m_axis_tdata[STATUS_W+POS_W-1:STATUS_W] == '0))
        else $error("nonzero position on failed operation");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before it was taken");

endmodule
